### sv/tbsw_pkg.sv
// Package: widths, fixed-point constants and pipeline stage types of the sample warp.
`timescale 1ns / 1ps

package tbsw_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned IN_W      = FRAC_BITS;
  localparam int unsigned ROOT_W    = FRAC_BITS + 1;
  localparam int unsigned RAD_W     = 2 * ROOT_W;
  localparam int unsigned REM_W     = ROOT_W + 3;
  localparam int unsigned OUT_W     = FRAC_BITS + 2;
  localparam int unsigned NUM_CELLS = ROOT_W;

  localparam logic [OUT_W-1:0] ONE  = OUT_W'(1) << FRAC_BITS;
  localparam logic [OUT_W-1:0] HALF = OUT_W'(1) << (FRAC_BITS - 1);

  localparam logic signed [OUT_W-1:0] ONE_S     = ONE;
  localparam logic signed [OUT_W-1:0] NEG_ONE_S = -ONE;

  typedef enum logic [1:0] {
    KIND_BOX,
    KIND_LO,
    KIND_HI
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [IN_W-1:0]   u;
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } stage_t;

endpackage

### sv/tbsw_if.sv
// Interfaces: sample input channel and warped result channel.
`timescale 1ns / 1ps

interface tbsw_in_if;
  logic                      valid;
  logic                      ready;
  logic [tbsw_pkg::IN_W-1:0] sample_x;
  logic [tbsw_pkg::IN_W-1:0] sample_y;
  logic                      last_sample;

  modport source (output valid, output sample_x, output sample_y, output last_sample,
                  input ready);
  modport sink (input valid, input sample_x, input sample_y, input last_sample,
                output ready);
endinterface

interface tbsw_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [tbsw_pkg::OUT_W-1:0] warped_x;
  logic signed [tbsw_pkg::OUT_W-1:0] warped_y;
  logic                              last_out;

  modport source (output valid, output warped_x, output warped_y, output last_out,
                  input ready);
  modport sink (input valid, input warped_x, input warped_y, input last_out,
                output ready);
endinterface

### sv/tbsw_prep.sv
// Front stage: classify each coordinate and form the square-root radicand.
`timescale 1ns / 1ps

module tbsw_prep (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             mode_i,
  tbsw_in_if.sink          sample_i,
  output logic             valid_o,
  output tbsw_pkg::stage_t data_o
);

  logic             valid_q;
  tbsw_pkg::stage_t data_q;
  tbsw_pkg::stage_t data_d;

  function automatic tbsw_pkg::coord_t prep_coord(logic [tbsw_pkg::IN_W-1:0] u, logic mode);
    logic [tbsw_pkg::ROOT_W-1:0] dbl;
    logic [tbsw_pkg::ROOT_W-1:0] d;
    tbsw_pkg::coord_t            c;
    dbl    = {u, 1'b0};
    c.u    = u;
    c.rem  = '0;
    c.root = '0;
    if (!mode) begin
      c.kind = tbsw_pkg::KIND_BOX;
      d      = '0;
    end else if (!u[tbsw_pkg::IN_W-1]) begin
      c.kind = tbsw_pkg::KIND_LO;
      d      = dbl;
    end else begin
      c.kind = tbsw_pkg::KIND_HI;
      d      = tbsw_pkg::ROOT_W'(0) - dbl;
    end
    c.rad = {1'b0, d, tbsw_pkg::FRAC_BITS'(0)};
    return c;
  endfunction

  assign sample_i.ready = adv_i;

  always_comb begin
    data_d.x    = prep_coord(sample_i.sample_x, mode_i);
    data_d.y    = prep_coord(sample_i.sample_y, mode_i);
    data_d.last = sample_i.last_sample;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### sv/tbsw_cell.sv
// Root cell: one restoring square-root digit step for both coordinates.
`timescale 1ns / 1ps

module tbsw_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             valid_i,
  input  tbsw_pkg::stage_t data_i,
  output logic             valid_o,
  output tbsw_pkg::stage_t data_o
);

  logic             valid_q;
  tbsw_pkg::stage_t data_q;
  tbsw_pkg::stage_t data_d;

  function automatic tbsw_pkg::coord_t root_step(tbsw_pkg::coord_t c);
    logic [tbsw_pkg::REM_W-1:0] ext;
    logic [tbsw_pkg::REM_W-1:0] trial;
    logic                       ge;
    tbsw_pkg::coord_t           r;
    ext    = {c.rem[tbsw_pkg::REM_W-3:0], c.rad[tbsw_pkg::RAD_W-1 -: 2]};
    trial  = {{(tbsw_pkg::REM_W - tbsw_pkg::ROOT_W - 2){1'b0}}, c.root, 2'b01};
    ge     = (ext >= trial);
    r      = c;
    r.rem  = ge ? (ext - trial) : ext;
    r.root = {c.root[tbsw_pkg::ROOT_W-2:0], ge};
    r.rad  = {c.rad[tbsw_pkg::RAD_W-3:0], 2'b00};
    return r;
  endfunction

  always_comb begin
    data_d.x    = root_step(data_i.x);
    data_d.y    = root_step(data_i.y);
    data_d.last = data_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### sv/tbsw_post.sv
// Output stage: form the warped coordinates and hold the result for transfer.
`timescale 1ns / 1ps

module tbsw_post (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  tbsw_pkg::stage_t data_i,
  tbsw_out_if.source       warp_o,
  output logic             adv_o
);

  logic                              valid_q;
  logic signed [tbsw_pkg::OUT_W-1:0] wx_q;
  logic signed [tbsw_pkg::OUT_W-1:0] wy_q;
  logic                              last_q;

  function automatic logic [tbsw_pkg::OUT_W-1:0] finish(tbsw_pkg::coord_t c);
    logic [tbsw_pkg::OUT_W-1:0] root_ext;
    logic [tbsw_pkg::OUT_W-1:0] u_ext;
    logic [tbsw_pkg::OUT_W-1:0] r;
    root_ext = {1'b0, c.root};
    u_ext    = {2'b00, c.u};
    case (c.kind)
      tbsw_pkg::KIND_BOX: r = u_ext - tbsw_pkg::HALF;
      tbsw_pkg::KIND_LO:  r = root_ext - tbsw_pkg::ONE;
      tbsw_pkg::KIND_HI:  r = tbsw_pkg::ONE - root_ext;
      default:            r = '0;
    endcase
    return r;
  endfunction

  assign adv_o = !valid_q || warp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      wx_q   <= finish(data_i.x);
      wy_q   <= finish(data_i.y);
      last_q <= data_i.last;
    end
  end

  assign warp_o.valid    = valid_q;
  assign warp_o.warped_x = wx_q;
  assign warp_o.warped_y = wy_q;
  assign warp_o.last_out = last_q;

endmodule

### sv/tent_box_sample_warp.sv
// Top level: box / tent warp of 2D sample points from the unit square into [-1,1].
//
// Each accepted sample gives one result after one front stage, a chain of 17 root
// cells that each resolve one bit of the integer square root for both coordinates,
// and one output register. The chain takes a new sample every cycle; a stall on
// the result channel holds the whole chain in place. filter_mode (mode_q) resets to
// 1 (tent); write it through cfg_we_i / cfg_wdata_i only while idle (not enforced).
`timescale 1ns / 1ps

module tent_box_sample_warp (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  tbsw_in_if.sink    sample_i,
  tbsw_out_if.source warp_o
);

  logic                                  mode_q;
  logic                                  adv;
  logic             [tbsw_pkg::NUM_CELLS:0] vld;
  tbsw_pkg::stage_t [tbsw_pkg::NUM_CELLS:0] stg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  tbsw_prep u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .mode_i   (mode_q),
    .sample_i (sample_i),
    .valid_o  (vld[0]),
    .data_o   (stg[0])
  );

  for (genvar i = 0; i < tbsw_pkg::NUM_CELLS; i++) begin : g_cell
    tbsw_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (vld[i]),
      .data_i  (stg[i]),
      .valid_o (vld[i+1]),
      .data_o  (stg[i+1])
    );
  end

  tbsw_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld[tbsw_pkg::NUM_CELLS]),
    .data_i  (stg[tbsw_pkg::NUM_CELLS]),
    .warp_o  (warp_o),
    .adv_o   (adv)
  );

`ifndef SYNTHESIS
  a_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    warp_o.valid |-> (warp_o.warped_x >= tbsw_pkg::NEG_ONE_S &&
                      warp_o.warped_x <= tbsw_pkg::ONE_S))
    else $error("warped_x outside [-1,1]");

  a_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    warp_o.valid |-> (warp_o.warped_y >= tbsw_pkg::NEG_ONE_S &&
                      warp_o.warped_y <= tbsw_pkg::ONE_S))
    else $error("warped_y outside [-1,1]");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld))
    else $error("root chain moved during a stall");

  a_ready_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warp_o.valid && !warp_o.ready) |-> !sample_i.ready)
    else $error("sample taken while result stalled and chain full");
`endif

endmodule
